FILE: hw/rtl/pfba_pkg.sv
package pfba_pkg;

  localparam int unsigned NumPages  = 16;
  localparam int unsigned ChunksMax = 64;
  localparam int unsigned PgIdxW    = 4;                 // page index
  localparam int unsigned PgW       = 5;                 // page index plus null
  localparam int unsigned SlIdxW    = 6;                 // slot index
  localparam int unsigned SlW       = 7;                 // slot index plus empty
  localparam int unsigned LinkAw    = PgIdxW + SlIdxW;

  localparam logic [PgW-1:0] PG_NULL  = PgW'(NumPages);
  localparam logic [SlW-1:0] SL_EMPTY = SlW'(ChunksMax);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FRAME = 2'd1;
  localparam logic [1:0] ST_UNMAPPED = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [PgIdxW-1:0] in_page;
    logic [SlIdxW-1:0] in_slot;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PgIdxW-1:0] out_page;
    logic [SlIdxW-1:0] out_slot;
    logic              page_released;
  } rsp_t;

  typedef struct packed {
    logic [SlW-1:0] in_use;
    logic [SlW-1:0] bumped;
    logic [SlW-1:0] fl_head;
    logic [PgW-1:0] nxt;
    logic [PgW-1:0] prv;
    logic           on_list;
  } page_rec_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_AHEAD,
    OP_MAP,
    OP_PUSH2,
    OP_TAKE,
    OP_LINK,
    OP_U0,
    OP_U1,
    OP_U2,
    OP_FREE,
    OP_EMIT
  } op_e;

  typedef struct packed {
    logic req_free;
    logic head_null;
    logic head_ok;
    logic no_frame;
    logic free_bad;
    logic free_last;
    logic need_push;
    logic full;
    logic u_off;
    logic out_busy;
  } dp_stat_t;

endpackage

FILE: hw/rtl/pfba_ctrl.sv
module pfba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pfba_pkg::dp_stat_t stat_i,
  output pfba_pkg::op_e     op_o
);
  import pfba_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_AHEAD = 4'd2;
  localparam logic [3:0] S_MAP   = 4'd3;
  localparam logic [3:0] S_PUSH2 = 4'd4;
  localparam logic [3:0] S_TAKE  = 4'd5;
  localparam logic [3:0] S_LINK  = 4'd6;
  localparam logic [3:0] S_U0    = 4'd7;
  localparam logic [3:0] S_U1    = 4'd8;
  localparam logic [3:0] S_U2    = 4'd9;
  localparam logic [3:0] S_FREE  = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0] state_q, state_d;
  logic [3:0] ret_q, ret_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    op_o    = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o    = OP_LOAD;
          state_d = S_START;
        end
      end
      S_START: begin
        state_d = stat_i.req_free ? S_FREE : S_AHEAD;
      end
      S_AHEAD: begin
        op_o = OP_AHEAD;
        if (stat_i.head_null) begin
          state_d = S_MAP;
        end else if (stat_i.head_ok) begin
          state_d = S_TAKE;
        end else begin
          // head page is exhausted: drop it and retry
          ret_d   = S_AHEAD;
          state_d = S_U0;
        end
      end
      S_MAP: begin
        op_o = OP_MAP;
        if (stat_i.no_frame) begin
          state_d = S_DONE;
        end else begin
          ret_d   = S_AHEAD;
          state_d = S_PUSH2;
        end
      end
      S_PUSH2: begin
        op_o    = OP_PUSH2;
        state_d = ret_q;
      end
      S_TAKE: begin
        op_o    = OP_TAKE;
        state_d = S_LINK;
      end
      S_LINK: begin
        op_o = OP_LINK;
        if (stat_i.full) begin
          ret_d   = S_DONE;
          state_d = S_U0;
        end else begin
          state_d = S_DONE;
        end
      end
      S_U0: begin
        op_o    = OP_U0;
        state_d = stat_i.u_off ? ret_q : S_U1;
      end
      S_U1: begin
        op_o    = OP_U1;
        state_d = S_U2;
      end
      S_U2: begin
        op_o    = OP_U2;
        state_d = ret_q;
      end
      S_FREE: begin
        op_o = OP_FREE;
        if (stat_i.free_bad) begin
          state_d = S_DONE;
        end else if (stat_i.free_last) begin
          ret_d   = S_DONE;
          state_d = S_U0;
        end else if (stat_i.need_push) begin
          ret_d   = S_DONE;
          state_d = S_PUSH2;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          op_o    = OP_EMIT;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

endmodule

FILE: hw/rtl/pfba_dp.sv
module pfba_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pfba_pkg::op_e      op_i,
  output pfba_pkg::dp_stat_t stat_o,
  input  pfba_pkg::req_t     in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pfba_pkg::rsp_t     out_data_o,
  input  logic               cfg_we_i,
  input  logic [6:0]         cfg_data_i
);
  import pfba_pkg::*;

  page_rec_t rec_q [NumPages];
  logic [NumPages-1:0] mapped_q, mapped_d;
  logic [PgW-1:0]      head_q, head_d;
  logic [6:0]          cpp_q;
  logic [SlW-1:0]      cpp_eff;

  req_t                req_q;
  logic [PgIdxW-1:0]   p_q, p_d;
  logic [PgW-1:0]      tmp_q, tmp_d;
  logic [PgW-1:0]      n_q, n_d;
  logic [PgW-1:0]      v_q, v_d;
  logic                fl_q, fl_d;
  logic                full_q, full_d;
  rsp_t                res_q, res_d;
  rsp_t                out_q;
  logic                out_valid_q;

  logic [SlW-1:0]      link_mem [NumPages*ChunksMax];
  logic [SlW-1:0]      link_rdata_q;
  logic                mem_we;
  logic [LinkAw-1:0]   mem_waddr, mem_raddr;
  logic [SlW-1:0]      mem_wdata;

  logic [PgIdxW-1:0]   raddr;
  page_rec_t           rd;
  logic                rec_we;
  logic [PgIdxW-1:0]   rec_waddr;
  page_rec_t           rec_wdata;

  logic [PgIdxW-1:0]   free_f;
  logic                free_found;
  logic [SlW-1:0]      inc_use;

  always_comb begin
    priority if (cpp_q == 7'd0) begin
      cpp_eff = SlW'(1);
    end else if (cpp_q > 7'(ChunksMax)) begin
      cpp_eff = SL_EMPTY;
    end else begin
      cpp_eff = cpp_q;
    end
  end

  // lowest unmapped frame
  always_comb begin
    free_f     = '0;
    free_found = 1'b0;
    for (int i = NumPages - 1; i >= 0; i--) begin
      if (!mapped_q[i]) begin
        free_f     = PgIdxW'(i);
        free_found = 1'b1;
      end
    end
  end

  always_comb begin
    unique case (op_i)
      OP_AHEAD: raddr = head_q[PgIdxW-1:0];
      OP_PUSH2: raddr = tmp_q[PgIdxW-1:0];
      OP_U1:    raddr = v_q[PgIdxW-1:0];
      OP_U2:    raddr = n_q[PgIdxW-1:0];
      OP_FREE:  raddr = req_q.in_page;
      default:  raddr = p_q;
    endcase
  end

  assign rd      = rec_q[raddr];
  assign inc_use = rd.in_use + SlW'(1);

  always_comb begin
    stat_o           = '0;
    stat_o.req_free  = (req_q.req_type == REQ_FREE);
    stat_o.head_null = (head_q == PG_NULL);
    stat_o.head_ok   = (rd.fl_head < SL_EMPTY) || (rd.bumped < cpp_eff);
    stat_o.no_frame  = !free_found;
    stat_o.free_bad  = !mapped_q[req_q.in_page];
    stat_o.free_last = (rd.in_use <= SlW'(1));
    stat_o.need_push = !rd.on_list;
    stat_o.full      = full_q;
    stat_o.u_off     = !rd.on_list;
    stat_o.out_busy  = out_valid_q && !out_ready_i;
  end

  always_comb begin
    mapped_d  = mapped_q;
    head_d    = head_q;
    p_d       = p_q;
    tmp_d     = tmp_q;
    n_d       = n_q;
    v_d       = v_q;
    fl_d      = fl_q;
    full_d    = full_q;
    res_d     = res_q;
    rec_we    = 1'b0;
    rec_waddr = raddr;
    rec_wdata = rd;
    mem_we    = 1'b0;
    mem_waddr = {req_q.in_page, req_q.in_slot};
    mem_wdata = rd.fl_head;
    mem_raddr = {p_q, rd.fl_head[SlIdxW-1:0]};
    unique case (op_i)
      OP_LOAD: begin
        res_d = '0;
      end
      OP_AHEAD: begin
        p_d = head_q[PgIdxW-1:0];
      end
      OP_MAP: begin
        if (free_found) begin
          mapped_d[free_f]  = 1'b1;
          rec_we            = 1'b1;
          rec_waddr         = free_f;
          rec_wdata.in_use  = '0;
          rec_wdata.bumped  = '0;
          rec_wdata.fl_head = SL_EMPTY;
          rec_wdata.nxt     = head_q;
          rec_wdata.prv     = PG_NULL;
          rec_wdata.on_list = 1'b1;
          tmp_d             = head_q;
          head_d            = {1'b0, free_f};
          p_d               = free_f;
        end else begin
          res_d.status = ST_NO_FRAME;
        end
      end
      OP_PUSH2: begin
        if (tmp_q != PG_NULL) begin
          rec_we        = 1'b1;
          rec_wdata.prv = {1'b0, p_q};
        end
      end
      OP_TAKE: begin
        rec_we           = 1'b1;
        rec_wdata.in_use = inc_use;
        full_d           = (inc_use >= cpp_eff);
        res_d.out_page   = p_q;
        if (rd.fl_head < SL_EMPTY) begin
          fl_d           = 1'b1;
          res_d.out_slot = rd.fl_head[SlIdxW-1:0];
        end else begin
          fl_d             = 1'b0;
          res_d.out_slot   = rd.bumped[SlIdxW-1:0];
          rec_wdata.bumped = rd.bumped + SlW'(1);
        end
      end
      OP_LINK: begin
        if (fl_q) begin
          rec_we            = 1'b1;
          rec_wdata.fl_head = link_rdata_q;
        end
      end
      OP_U0: begin
        n_d = rd.nxt;
        v_d = rd.prv;
        if (rd.on_list) begin
          rec_we            = 1'b1;
          rec_wdata.nxt     = PG_NULL;
          rec_wdata.prv     = PG_NULL;
          rec_wdata.on_list = 1'b0;
        end
      end
      OP_U1: begin
        if (v_q != PG_NULL) begin
          rec_we        = 1'b1;
          rec_wdata.nxt = n_q;
        end else begin
          head_d = n_q;
        end
      end
      OP_U2: begin
        if (n_q != PG_NULL) begin
          rec_we        = 1'b1;
          rec_wdata.prv = v_q;
        end
      end
      OP_FREE: begin
        p_d = req_q.in_page;
        if (!mapped_q[req_q.in_page]) begin
          res_d.status = ST_UNMAPPED;
        end else if (rd.in_use <= SlW'(1)) begin
          // last chunk: release the frame, unlink follows
          rec_we                    = 1'b1;
          rec_wdata.in_use          = '0;
          rec_wdata.bumped          = '0;
          rec_wdata.fl_head         = SL_EMPTY;
          mapped_d[req_q.in_page]   = 1'b0;
          res_d.page_released       = 1'b1;
        end else begin
          rec_we            = 1'b1;
          rec_wdata.in_use  = rd.in_use - SlW'(1);
          rec_wdata.fl_head = {1'b0, req_q.in_slot};
          mem_we            = 1'b1;
          if (!rd.on_list) begin
            rec_wdata.nxt     = head_q;
            rec_wdata.prv     = PG_NULL;
            rec_wdata.on_list = 1'b1;
            tmp_d             = head_q;
            head_d            = {1'b0, req_q.in_page};
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mapped_q    <= '0;
      head_q      <= PG_NULL;
      cpp_q       <= 7'd64;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumPages; i++) begin
        rec_q[i] <= '{in_use: '0, bumped: '0, fl_head: SL_EMPTY,
                      nxt: PG_NULL, prv: PG_NULL, on_list: 1'b0};
      end
    end else begin
      mapped_q <= mapped_d;
      head_q   <= head_d;
      if (cfg_we_i) begin
        cpp_q <= cfg_data_i;
      end
      if (rec_we) begin
        rec_q[rec_waddr] <= rec_wdata;
      end
      if (op_i == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_LOAD) begin
      req_q <= in_data_i;
    end
    if (op_i == OP_EMIT) begin
      out_q <= res_q;
    end
    p_q    <= p_d;
    tmp_q  <= tmp_d;
    n_q    <= n_d;
    v_q    <= v_d;
    fl_q   <= fl_d;
    full_q <= full_d;
    res_q  <= res_d;
  end

  // chunk link memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    link_rdata_q <= link_mem[mem_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: hw/rtl/paged_fixed_block_allocator.sv
// Allocate drops each exhausted head page it meets before it takes a chunk;
//   a new result waits while an earlier result is not yet taken, holding the block.
// Throughput: one request at a time; the per-page record file has one port,
//   so every list edit is a step of its own.
// Reset: asynchronous, active low; all frames unmapped, partial list empty,
//   chunks_per_page 64. The chunk link memory is not cleared.
module paged_fixed_block_allocator (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pfba_pkg::req_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pfba_pkg::rsp_t   out_data_o,
  input  logic             cfg_we_i,
  input  logic [6:0]       cfg_data_i
);
  import pfba_pkg::*;

  op_e      op;
  dp_stat_t stat;

  pfba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .op_o       (op)
  );

  pfba_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status != 2'd3))
    else $error("invalid status code");

  a_release_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.page_released) |-> (out_data_o.status == ST_OK))
    else $error("page released on failed request");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready while request in flight");

endmodule
